// ===== sv/ttes_pkg.sv =====
// shared types and constants of the tempo tick event sequencer
package ttes_pkg;

   localparam int unsigned TICK_W    = 24;
   localparam int unsigned TEMPO_W   = 16;
   localparam int unsigned COUNT_W   = 9;
   localparam int unsigned FRAC_W    = 17;
   localparam int unsigned EMIT_W    = 6;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 24;

   localparam logic [FRAC_W-1:0]  FRAC_MODULUS = 17'd32000;
   localparam logic [EMIT_W-1:0]  EMIT_LIMIT   = 6'd63;
   localparam logic [TEMPO_W-1:0] TEMPO_RESET  = 16'd30720;

   typedef enum logic [1:0] {
      KIND_MS     = 2'd0,
      KIND_LOAD   = 2'd1,
      KIND_REWIND = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEMPO       = 3'd0,
      CSR_RUN         = 3'd1,
      CSR_LOOP_ENABLE = 3'd2,
      CSR_LOOP_FIRST  = 3'd3,
      CSR_LOOP_LIMIT  = 3'd4,
      CSR_EVENT_COUNT = 3'd5
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_SCAN,
      ST_DRAIN,
      ST_READ,
      ST_OUT,
      ST_STATUS
   } state_type;

   typedef struct packed {
      logic [TICK_W-1:0] tick;
      logic [3:0]        code;
      logic [3:0]        channel;
      logic [6:0]        pitch;
      logic [6:0]        velocity;
   } entry_type;

   typedef struct packed {
      logic start;
      logic add_tempo;
      logic load;
      logic rewind;
      logic tick_step;
      logic scan_clear;
      logic scan_issue;
      logic buf_read;
      logic buf_next;
      logic show_event;
   } cmd_type;

   typedef struct packed {
      logic run;
      logic frac_ge;
      logic tick_moves;
      logic scan_end;
      logic emit_end;
   } sts_type;

endpackage

// ===== sv/ttes_ctrl.sv =====
// controller state machine: item sequencing, tick loop, scan and result output
module ttes_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_kind,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_is_event,
   output logic                rsp_last,
   output ttes_pkg::cmd_type   cmd,
   input  ttes_pkg::sts_type   sts
);
   import ttes_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      rsp_is_event = 1'b0;
      rsp_last     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_STATUS;
               unique case (kind_type'(req_kind))
                  KIND_MS: begin
                     if (sts.run) begin
                        cmd.add_tempo = 1'b1;
                        state_in      = ST_TICK;
                     end
                  end
                  KIND_LOAD:   cmd.load = 1'b1;
                  KIND_REWIND: cmd.rewind = 1'b1;
                  KIND_NONE:   cmd.start = 1'b1;
                  default:     cmd.start = 1'b1;
               endcase
            end
         end
         ST_TICK: begin
            if (sts.frac_ge) begin
               cmd.tick_step  = 1'b1;
               cmd.scan_clear = 1'b1;
               if (sts.tick_moves) begin
                  state_in = ST_SCAN;
               end
            end else begin
               state_in = ST_READ;
            end
         end
         ST_SCAN: begin
            if (sts.scan_end) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.scan_issue = 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_TICK;
         end
         ST_READ: begin
            if (sts.emit_end) begin
               state_in = ST_STATUS;
            end else begin
               cmd.buf_read = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_valid      = 1'b1;
            rsp_is_event   = 1'b1;
            cmd.show_event = 1'b1;
            if (rsp_ready) begin
               cmd.buf_next = 1'b1;
               state_in     = ST_READ;
            end
         end
         ST_STATUS: begin
            rsp_valid = 1'b1;
            rsp_last  = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== sv/ttes_datapath.sv =====
// datapath: registers, event table, tick arithmetic, match scan and result buffer
module ttes_datapath #(
   parameter int unsigned EVENT_SLOTS = 256,
   parameter int unsigned TICK_BITS   = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [ttes_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ttes_pkg::CSR_DAT_W-1:0]       csr_wdata,
   input  logic [7:0]                           req_slot,
   input  logic [23:0]                          req_ev_tick,
   input  logic [3:0]                           req_ev_type,
   input  logic [3:0]                           req_ev_channel,
   input  logic [6:0]                           req_ev_pitch,
   input  logic [6:0]                           req_ev_velocity,
   output logic [23:0]                          rsp_out_tick,
   output logic [3:0]                           rsp_out_type,
   output logic [3:0]                           rsp_out_channel,
   output logic [6:0]                           rsp_out_pitch,
   output logic [6:0]                           rsp_out_velocity,
   output logic [23:0]                          rsp_position_now,
   output logic                                 rsp_dropped,
   input  ttes_pkg::cmd_type                    cmd,
   output ttes_pkg::sts_type                    sts
);
   import ttes_pkg::*;

   localparam int unsigned SLOT_W  = $clog2(EVENT_SLOTS);
   localparam int unsigned SCAN_W  = $clog2(EVENT_SLOTS + 1);
   localparam int unsigned CMP_W   = ((TICK_BITS > TICK_W) ? TICK_BITS : TICK_W) + 1;
   localparam int unsigned BUF_DEPTH = 1 << EMIT_W;

   // configuration registers
   logic [TEMPO_W-1:0] tempo_ff;
   logic               run_ff;
   logic               loop_en_ff;
   logic [TICK_W-1:0]  loop_first_ff;
   logic [TICK_W-1:0]  loop_limit_ff;
   logic [COUNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tempo_ff      <= TEMPO_RESET;
         run_ff        <= 1'b0;
         loop_en_ff    <= 1'b0;
         loop_first_ff <= '0;
         loop_limit_ff <= '0;
         count_ff      <= '0;
      end else if (csr_we) begin
         unique case (csr_type'(csr_index))
            CSR_TEMPO:       tempo_ff      <= csr_wdata[TEMPO_W-1:0];
            CSR_RUN:         run_ff        <= csr_wdata[0];
            CSR_LOOP_ENABLE: loop_en_ff    <= csr_wdata[0];
            CSR_LOOP_FIRST:  loop_first_ff <= csr_wdata[TICK_W-1:0];
            CSR_LOOP_LIMIT:  loop_limit_ff <= csr_wdata[TICK_W-1:0];
            CSR_EVENT_COUNT: count_ff      <= csr_wdata[COUNT_W-1:0];
            default:         run_ff        <= run_ff;
         endcase
      end
   end

   // position and fraction
   logic [FRAC_W-1:0]    frac_ff;
   logic [FRAC_W-1:0]    frac_in;
   logic [TICK_BITS-1:0] pos_ff;
   logic [TICK_BITS-1:0] pos_in;
   logic [CMP_W-1:0]     next_w;
   logic [CMP_W-1:0]     first_w;
   logic [CMP_W-1:0]     max_w;
   logic [CMP_W-1:0]     target_w;
   logic                 wrap;
   logic                 moves;

   always_comb begin
      next_w   = CMP_W'(pos_ff) + CMP_W'(1);
      first_w  = CMP_W'(loop_first_ff);
      max_w    = CMP_W'({TICK_BITS{1'b1}});
      target_w = (first_w > max_w) ? max_w : first_w;
      wrap     = loop_en_ff && (next_w >= CMP_W'(loop_limit_ff));
      moves    = wrap || (pos_ff != {TICK_BITS{1'b1}});
      frac_in  = frac_ff;
      pos_in   = pos_ff;
      if (cmd.add_tempo) begin
         frac_in = frac_ff + FRAC_W'(tempo_ff);
      end else if (cmd.tick_step) begin
         frac_in = frac_ff - FRAC_MODULUS;
      end
      if (cmd.rewind) begin
         pos_in = '0;
      end else if (cmd.tick_step && moves) begin
         pos_in = wrap ? target_w[TICK_BITS-1:0] : next_w[TICK_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff <= '0;
         pos_ff  <= '0;
      end else begin
         frac_ff <= frac_in;
         pos_ff  <= pos_in;
      end
   end

   // event table
   entry_type store_mem [EVENT_SLOTS];
   entry_type store_rd_ff;
   entry_type load_word;
   logic      load_in_range;

   assign load_word     = '{tick: req_ev_tick, code: req_ev_type, channel: req_ev_channel,
                            pitch: req_ev_pitch, velocity: req_ev_velocity};
   assign load_in_range = 32'(req_slot) < EVENT_SLOTS;

   // scan control
   logic [SCAN_W-1:0] scan_addr_ff;
   logic [SCAN_W-1:0] scan_lim;
   logic              hit_v_ff;

   assign scan_lim = (32'(count_ff) > EVENT_SLOTS) ? SCAN_W'(EVENT_SLOTS)
                                                   : SCAN_W'(count_ff);

   always_ff @(posedge clock) begin
      if (cmd.load && load_in_range) begin
         store_mem[SLOT_W'(req_slot)] <= load_word;
      end
      if (cmd.scan_issue) begin
         store_rd_ff <= store_mem[scan_addr_ff[SLOT_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff <= '0;
         hit_v_ff     <= 1'b0;
      end else begin
         hit_v_ff <= cmd.scan_issue;
         if (cmd.scan_clear) begin
            scan_addr_ff <= '0;
         end else if (cmd.scan_issue) begin
            scan_addr_ff <= scan_addr_ff + SCAN_W'(1);
         end
      end
   end

   // match and result buffer
   logic              hit;
   logic              keep;
   logic [EMIT_W-1:0] nemit_ff;
   logic [EMIT_W-1:0] emit_idx_ff;
   logic              dropped_ff;
   entry_type         buf_mem [BUF_DEPTH];
   entry_type         buf_rd_ff;

   assign hit  = hit_v_ff && (CMP_W'(store_rd_ff.tick) == CMP_W'(pos_ff));
   assign keep = hit && (nemit_ff != EMIT_LIMIT);

   always_ff @(posedge clock) begin
      if (keep) begin
         buf_mem[nemit_ff] <= store_rd_ff;
      end
      if (cmd.buf_read) begin
         buf_rd_ff <= buf_mem[emit_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nemit_ff    <= '0;
         emit_idx_ff <= '0;
         dropped_ff  <= 1'b0;
      end else if (cmd.start) begin
         nemit_ff    <= '0;
         emit_idx_ff <= '0;
         dropped_ff  <= 1'b0;
      end else begin
         if (keep) begin
            nemit_ff <= nemit_ff + EMIT_W'(1);
         end
         if (hit && !keep) begin
            dropped_ff <= 1'b1;
         end
         if (cmd.buf_next) begin
            emit_idx_ff <= emit_idx_ff + EMIT_W'(1);
         end
      end
   end

   assign sts.run        = run_ff;
   assign sts.frac_ge    = frac_ff >= FRAC_MODULUS;
   assign sts.tick_moves = moves;
   assign sts.scan_end   = scan_addr_ff == scan_lim;
   assign sts.emit_end   = emit_idx_ff == nemit_ff;

   // result word
   assign rsp_out_tick     = cmd.show_event ? buf_rd_ff.tick     : '0;
   assign rsp_out_type     = cmd.show_event ? buf_rd_ff.code     : '0;
   assign rsp_out_channel  = cmd.show_event ? buf_rd_ff.channel  : '0;
   assign rsp_out_pitch    = cmd.show_event ? buf_rd_ff.pitch    : '0;
   assign rsp_out_velocity = cmd.show_event ? buf_rd_ff.velocity : '0;
   assign rsp_position_now = TICK_W'(pos_ff);
   assign rsp_dropped      = cmd.show_event ? 1'b0 : dropped_ff;

endmodule

// ===== sv/tempo_tick_event_sequencer.sv =====
// a load, rewind, stopped or unknown word has its status word offered in the cycle after accept
// millisecond word: adds tempo to the fraction; each whole tick steps the position and scans the
// counted slots (skipped when the position cannot move), then kept events and status are offered
// one word in flight: the next word can be accepted in the cycle after the status word is taken
// reset: configuration to defaults, position and fraction to zero; event table not cleared
module tempo_tick_event_sequencer #(
   parameter int unsigned EVENT_SLOTS = 256,
   parameter int unsigned TICK_BITS   = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [ttes_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ttes_pkg::CSR_DAT_W-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_kind,
   input  logic [7:0]                     req_slot,
   input  logic [23:0]                    req_ev_tick,
   input  logic [3:0]                     req_ev_type,
   input  logic [3:0]                     req_ev_channel,
   input  logic [6:0]                     req_ev_pitch,
   input  logic [6:0]                     req_ev_velocity,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_is_event,
   output logic [23:0]                    rsp_out_tick,
   output logic [3:0]                     rsp_out_type,
   output logic [3:0]                     rsp_out_channel,
   output logic [6:0]                     rsp_out_pitch,
   output logic [6:0]                     rsp_out_velocity,
   output logic [23:0]                    rsp_position_now,
   output logic                           rsp_dropped,
   output logic                           rsp_last
);
   import ttes_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ttes_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_kind     (req_kind),
      .req_ready    (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_is_event (rsp_is_event),
      .rsp_last     (rsp_last),
      .cmd          (cmd),
      .sts          (sts)
   );

   ttes_datapath #(
      .EVENT_SLOTS (EVENT_SLOTS),
      .TICK_BITS   (TICK_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_slot         (req_slot),
      .req_ev_tick      (req_ev_tick),
      .req_ev_type      (req_ev_type),
      .req_ev_channel   (req_ev_channel),
      .req_ev_pitch     (req_ev_pitch),
      .req_ev_velocity  (req_ev_velocity),
      .rsp_out_tick     (rsp_out_tick),
      .rsp_out_type     (rsp_out_type),
      .rsp_out_channel  (rsp_out_channel),
      .rsp_out_pitch    (rsp_out_pitch),
      .rsp_out_velocity (rsp_out_velocity),
      .rsp_position_now (rsp_position_now),
      .rsp_dropped      (rsp_dropped),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

// ===== tb/sv/tick_event_checker.sv =====
// scoreboard of the tempo tick event sequencer: predicts every result word and compares it
module tick_event_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [ttes_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ttes_pkg::CSR_DAT_W-1:0] csr_wdata,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [1:0]                     req_kind,
   input  logic [7:0]                     req_slot,
   input  logic [23:0]                    req_ev_tick,
   input  logic [3:0]                     req_ev_type,
   input  logic [3:0]                     req_ev_channel,
   input  logic [6:0]                     req_ev_pitch,
   input  logic [6:0]                     req_ev_velocity,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_is_event,
   input  logic [23:0]                    rsp_out_tick,
   input  logic [3:0]                     rsp_out_type,
   input  logic [3:0]                     rsp_out_channel,
   input  logic [6:0]                     rsp_out_pitch,
   input  logic [6:0]                     rsp_out_velocity,
   input  logic [23:0]                    rsp_position_now,
   input  logic                           rsp_dropped,
   input  logic                           rsp_last,
   output int                             mismatches,
   output int                             words_due
);
   import ttes_pkg::*;

   localparam int TABLE_SLOTS = 256;

   typedef struct packed {
      logic              is_event;
      logic [TICK_W-1:0] tick;
      logic [3:0]        code;
      logic [3:0]        channel;
      logic [6:0]        pitch;
      logic [6:0]        velocity;
      logic [TICK_W-1:0] position;
      logic              dropped;
      logic              last;
   } seq_word_type;

   logic [TEMPO_W-1:0] tempo;
   logic               run_on;
   logic               loop_on;
   logic [TICK_W-1:0]  loop_start;
   logic [TICK_W-1:0]  loop_end;
   logic [COUNT_W-1:0] slots_used;
   logic [TICK_W-1:0]  song_pos;
   int unsigned        fraction;
   entry_type          event_table [TABLE_SLOTS];
   seq_word_type       due_words [$];

   task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   // one tick of song position; returns 0 when saturated
   function automatic bit advance_one();
      logic [TICK_W:0] next;
      next = {1'b0, song_pos} + (TICK_W+1)'(1);
      if (loop_on && next >= {1'b0, loop_end}) begin
         song_pos = loop_start;
         return 1'b1;
      end
      if (next[TICK_W]) return 1'b0;
      song_pos = next[TICK_W-1:0];
      return 1'b1;
   endfunction

   task automatic predict_word(input logic [1:0] kind, input logic [7:0] slot,
                               input entry_type load);
      seq_word_type hits [$];
      seq_word_type w;
      int unsigned  sum;
      int unsigned  scan;
      bit           lost;
      lost = 1'b0;
      case (kind_type'(kind))
         KIND_MS: begin
            if (run_on) begin
               sum = fraction + 32'(tempo);
               scan = (32'(slots_used) > TABLE_SLOTS) ? TABLE_SLOTS : 32'(slots_used);
               while (sum >= 32'(FRAC_MODULUS)) begin
                  sum -= 32'(FRAC_MODULUS);
                  if (advance_one()) begin
                     for (int s = 0; s < scan; s++) begin
                        if (event_table[s].tick == song_pos) begin
                           if (hits.size() >= int'(EMIT_LIMIT)) begin
                              lost = 1'b1;
                           end else begin
                              w = '0;
                              w.is_event = 1'b1;
                              w.tick     = event_table[s].tick;
                              w.code     = event_table[s].code;
                              w.channel  = event_table[s].channel;
                              w.pitch    = event_table[s].pitch;
                              w.velocity = event_table[s].velocity;
                              hits.push_back(w);
                           end
                        end
                     end
                  end
               end
               fraction = sum;
            end
         end
         KIND_LOAD: begin
            if (32'(slot) < TABLE_SLOTS) event_table[slot] = load;
         end
         KIND_REWIND: begin
            song_pos = '0;
         end
         default: ;
      endcase
      foreach (hits[i]) begin
         hits[i].position = song_pos;
         due_words.push_back(hits[i]);
      end
      w = '0;
      w.position = song_pos;
      w.dropped  = lost;
      w.last     = 1'b1;
      due_words.push_back(w);
   endtask

   task automatic check_word();
      seq_word_type want;
      if (due_words.size() == 0) begin
         flag("word with nothing due, is_event", 32'(rsp_is_event), 32'd0);
         return;
      end
      want = due_words.pop_front();
      if (rsp_is_event !== want.is_event) begin
         flag("is_event", 32'(rsp_is_event), 32'(want.is_event));
      end
      if (rsp_out_tick !== want.tick) flag("out_tick", 32'(rsp_out_tick), 32'(want.tick));
      if (rsp_out_type !== want.code) flag("out_type", 32'(rsp_out_type), 32'(want.code));
      if (rsp_out_channel !== want.channel) begin
         flag("out_channel", 32'(rsp_out_channel), 32'(want.channel));
      end
      if (rsp_out_pitch !== want.pitch) begin
         flag("out_pitch", 32'(rsp_out_pitch), 32'(want.pitch));
      end
      if (rsp_out_velocity !== want.velocity) begin
         flag("out_velocity", 32'(rsp_out_velocity), 32'(want.velocity));
      end
      if (rsp_position_now !== want.position) begin
         flag("position_now", 32'(rsp_position_now), 32'(want.position));
      end
      if (rsp_dropped !== want.dropped) begin
         flag("dropped", 32'(rsp_dropped), 32'(want.dropped));
      end
      if (rsp_last !== want.last) flag("last", 32'(rsp_last), 32'(want.last));
   endtask

   task automatic apply_setting();
      case (csr_type'(csr_index))
         CSR_TEMPO:       tempo      = csr_wdata[TEMPO_W-1:0];
         CSR_RUN:         run_on     = csr_wdata[0];
         CSR_LOOP_ENABLE: loop_on    = csr_wdata[0];
         CSR_LOOP_FIRST:  loop_start = csr_wdata[TICK_W-1:0];
         CSR_LOOP_LIMIT:  loop_end   = csr_wdata[TICK_W-1:0];
         CSR_EVENT_COUNT: slots_used = csr_wdata[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tempo      = TEMPO_RESET;
         run_on     = 1'b0;
         loop_on    = 1'b0;
         loop_start = '0;
         loop_end   = '0;
         slots_used = '0;
         song_pos   = '0;
         fraction   = 0;
         mismatches = 0;
         due_words.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_word();
         if (req_valid && req_ready) begin
            predict_word(req_kind, req_slot, {req_ev_tick, req_ev_type, req_ev_channel,
                                              req_ev_pitch, req_ev_velocity});
         end
         if (csr_we) apply_setting();
      end
      words_due <= due_words.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
// top of the sequencer testbench: clock, reset, stimulus, ready stalls and verdict
module tb;
   import ttes_pkg::*;

   localparam int FILL_SLOTS  = 80;
   localparam int CYCLE_LIMIT = 4000000;

   logic                 clock           = 1'b0;
   logic                 reset           = 1'b1;
   logic                 csr_we          = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index       = '0;
   logic [CSR_DAT_W-1:0] csr_wdata       = '0;
   logic                 req_valid       = 1'b0;
   logic [1:0]           req_kind        = KIND_MS;
   logic [7:0]           req_slot        = '0;
   logic [23:0]          req_ev_tick     = '0;
   logic [3:0]           req_ev_type     = '0;
   logic [3:0]           req_ev_channel  = '0;
   logic [6:0]           req_ev_pitch    = '0;
   logic [6:0]           req_ev_velocity = '0;
   logic                 rsp_ready       = 1'b0;
   logic                 req_ready;
   logic                 rsp_valid;
   logic                 rsp_is_event;
   logic [23:0]          rsp_out_tick;
   logic [3:0]           rsp_out_type;
   logic [3:0]           rsp_out_channel;
   logic [6:0]           rsp_out_pitch;
   logic [6:0]           rsp_out_velocity;
   logic [23:0]          rsp_position_now;
   logic                 rsp_dropped;
   logic                 rsp_last;

   int          mismatches;
   int          words_due;
   int          cycles = 0;
   int unsigned rsp_hold = 0;
   int unsigned rsp_pause;
   bit          rsp_calm = 1'b0;
   bit          req_calm = 1'b0;

   always #2 clock = ~clock;

   tempo_tick_event_sequencer dut (.*);

   tick_event_checker watch (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("** tempo_tick_event_sequencer: FAILED **");
         $finish;
      end
   end

   // result side stalls at random after a taken word
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_ready) begin
         if (rsp_valid) begin
            if ($urandom_range(0, 31) == 0) rsp_calm <= !rsp_calm;
            rsp_pause = rsp_calm ? 0 : $urandom_range(0, 8);
            if (rsp_pause != 0) begin
               rsp_ready <= 1'b0;
               rsp_hold  <= rsp_pause;
            end
         end
      end else if (rsp_hold > 1) begin
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic entry_type note(input logic [23:0] tick);
      entry_type ev;
      ev.tick     = tick;
      ev.code     = 4'($urandom_range(0, 15));
      ev.channel  = 4'($urandom_range(0, 15));
      ev.pitch    = 7'($urandom_range(0, 127));
      ev.velocity = 7'($urandom_range(0, 127));
      return ev;
   endfunction

   function automatic logic [23:0] any_tick();
      return 24'($urandom_range(0, 24'hFFFFFF));
   endfunction

   task automatic send(input kind_type kind, input logic [7:0] slot, input entry_type ev);
      int unsigned gap;
      gap = req_calm ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_slot        <= slot;
      req_ev_tick     <= ev.tick;
      req_ev_type     <= ev.code;
      req_ev_channel  <= ev.channel;
      req_ev_pitch    <= ev.pitch;
      req_ev_velocity <= ev.velocity;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic put(input csr_type idx, input logic [CSR_DAT_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] tempo, input bit run, input bit loop,
                            input logic [23:0] first, input logic [23:0] limit,
                            input logic [8:0] count);
      settle();
      put(CSR_TEMPO, CSR_DAT_W'(tempo));
      put(CSR_RUN, CSR_DAT_W'(run));
      put(CSR_LOOP_ENABLE, CSR_DAT_W'(loop));
      put(CSR_LOOP_FIRST, first);
      put(CSR_LOOP_LIMIT, limit);
      put(CSR_EVENT_COUNT, CSR_DAT_W'(count));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int unsigned pick;
      logic [15:0] tempo;
      logic [23:0] first;
      logic [23:0] limit;
      logic [8:0]  count;
      logic [23:0] tick;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: stopped, unknown kind, rewind
      send(KIND_MS, 8'h00, '0);
      send(KIND_NONE, 8'hFF, '1);
      send(KIND_REWIND, 8'h5A, note(any_tick()));
      send(KIND_LOAD, 8'd0, '{24'd1, 4'hF, 4'hF, 7'h7F, 7'h7F});
      send(KIND_LOAD, 8'd1, '{24'd1, 4'h0, 4'h0, 7'h00, 7'h00});
      send(KIND_LOAD, 8'd2, note(24'd2));
      send(KIND_LOAD, 8'd3, note(24'hFFFFFF));
      send(KIND_LOAD, 8'd4, note(24'd0));
      send(KIND_LOAD, 8'd5, note(24'd3));
      send(KIND_LOAD, 8'd255, note(any_tick()));

      configure(16'hFFFF, 1'b1, 1'b0, 24'd0, 24'd0, 9'd6);
      repeat (3) send(KIND_MS, 8'h00, note(any_tick()));
      configure(16'h0000, 1'b1, 1'b0, 24'd0, 24'd0, 9'd6);
      send(KIND_MS, 8'h00, '0);
      configure(16'd30720, 1'b1, 1'b0, 24'd0, 24'd0, 9'd6);
      send(KIND_MS, 8'h00, '0);
      // wrap straight to the top tick, then saturate there
      configure(16'hFFFF, 1'b1, 1'b1, 24'hFFFFFF, 24'd0, 9'd6);
      repeat (2) send(KIND_MS, 8'h00, '0);
      configure(16'hFFFF, 1'b1, 1'b0, 24'hFFFFFF, 24'd0, 9'd6);
      send(KIND_MS, 8'h00, '0);
      send(KIND_REWIND, 8'h00, '0);
      send(KIND_NONE, 8'h00, '0);
      configure(16'hFFFF, 1'b1, 1'b1, 24'd1, 24'd3, 9'd6);
      repeat (3) send(KIND_MS, 8'h00, '0);
      configure(16'd30720, 1'b0, 1'b0, 24'd0, 24'd0, 9'd6);
      send(KIND_MS, 8'h00, '0);

      // load a block of slots with clustered ticks so one word overflows
      for (int s = 0; s < FILL_SLOTS; s++) begin
         tick = ($urandom_range(0, 15) == 0) ? any_tick() : 24'($urandom_range(0, 1));
         send(KIND_LOAD, s[7:0], note(tick));
      end
      configure(16'hFFFF, 1'b1, 1'b1, 24'd0, 24'd2, 9'(FILL_SLOTS));
      repeat (4) send(KIND_MS, 8'h00, '0);
      configure(16'd20000, 1'b1, 1'b1, 24'd1, 24'd1, 9'(FILL_SLOTS));
      repeat (2) send(KIND_MS, 8'h00, '0);
      configure(16'hFFFF, 1'b1, 1'b0, 24'd0, 24'd0, 9'd0);
      send(KIND_MS, 8'h00, '0);
      send(KIND_REWIND, 8'h00, '0);

      for (int phase = 0; phase < 5; phase++) begin
         req_calm = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 5);
         case (pick)
            0: tempo = 16'h0000;
            1: tempo = 16'hFFFF;
            2: tempo = 16'($urandom_range(0, 16'hFFFF));
            default: tempo = 16'($urandom_range(16000, 16'hFFFF));
         endcase
         first = ($urandom_range(0, 7) == 0) ? any_tick() : 24'($urandom_range(0, 40));
         limit = ($urandom_range(0, 7) == 0) ? 24'hFFFFFF : 24'($urandom_range(0, 48));
         count = ($urandom_range(0, 7) == 0) ? 9'(FILL_SLOTS) : 9'($urandom_range(0, 48));
         configure(tempo, $urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)), first, limit,
                   count);
         repeat (18) begin
            pick = $urandom_range(0, 99);
            tick = ($urandom_range(0, 7) == 0) ? any_tick() : 24'($urandom_range(0, 63));
            if (pick < 70) send(KIND_MS, 8'($urandom_range(0, 255)), note(any_tick()));
            else if (pick < 85) send(KIND_LOAD, 8'($urandom_range(0, 255)), note(tick));
            else if (pick < 93) begin
               send(KIND_REWIND, 8'($urandom_range(0, 255)), note(any_tick()));
            end else begin
               send(KIND_NONE, 8'($urandom_range(0, 255)), note(any_tick()));
            end
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("** tempo_tick_event_sequencer: PASSED **");
      end else begin
         $display("** tempo_tick_event_sequencer: FAILED **");
      end
      $finish;
   end

endmodule
